/* design/deq_pkg.sv */
// Shared types and constants of the double-ended queue.
package deq_pkg;

  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_DUMP       = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHR,
    CELL_SHL,
    CELL_ROT,
    CELL_APPEND
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTB,
    ST_POPB,
    ST_DUMP
  } state_t;

endpackage

/* design/deq_cell.sv */
// One storage cell of the queue chain: a value and its occupied flag.
module deq_cell
  import deq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] push_value,
  input  logic [DATA_W-1:0] left_data,
  input  logic              left_valid,
  input  logic [DATA_W-1:0] right_data,
  input  logic              right_valid,
  input  logic [DATA_W-1:0] head_data,
  output logic [DATA_W-1:0] data_o,
  output logic              valid_o
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    unique case (op)
      CELL_HOLD: begin
      end
      CELL_SHR: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      CELL_SHL: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
      end
      CELL_ROT: begin
        // The back cell wraps the head value around; the others shift toward the front.
        if (valid_r && !right_valid) begin
          data_nxt = head_data;
        end else if (valid_r) begin
          data_nxt = right_data;
        end
      end
      CELL_APPEND: begin
        if (!valid_r && left_valid) begin
          data_nxt  = push_value;
          valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

/* design/double_ended_queue.sv */
// Double-ended queue built as a chain of cells with the front entry in cell zero.
// Push front, push back and pop front act on the chain in the accept cycle and register their result.
// Pop back of more than one entry rotates the chain in ST_ROTB until the back entry is in cell zero,
// then pops it in ST_POPB once the output register is free, and the result is registered.
// Dump rotates the chain once per result, one entry per cycle when the output is taken.
// The output register lets a new transfer enter while a result is being taken.
// Synchronous active-low reset empties the queue and clears the output valid flag.
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 32
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic [MODE_W-1:0]   in_tuser,   // [2:0] mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DATA_W-1:0]   out_tdata,  // [31:0] data
  output logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  output logic                out_tlast
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_valid [DEPTH];
  logic [DEPTH-1:0]  valid_vec;
  cell_op_t          cell_op;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  logic              out_free;
  logic              accept;
  mode_t             mode;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;
      if (gi == 0) begin : g_first
        assign l_data  = in_tdata;
        assign l_valid = 1'b1;
      end else begin : g_mid_l
        assign l_data  = cell_data[gi-1];
        assign l_valid = cell_valid[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_mid_r
        assign r_data  = cell_data[gi+1];
        assign r_valid = cell_valid[gi+1];
      end
      deq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (cell_op),
        .push_value  (in_tdata),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .head_data   (cell_data[0]),
        .data_o      (cell_data[gi]),
        .valid_o     (cell_valid[gi])
      );
      assign valid_vec[gi] = cell_valid[gi];
    end
  endgenerate

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign mode      = mode_t'(in_tuser);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    cell_op        = CELL_HOLD;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
              out_last_nxt  = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                out_status_nxt = STAT_OK;
                cell_op        = (mode == MODE_PUSH_FRONT) ? CELL_SHR : CELL_APPEND;
                count_nxt      = count_r + CW'(1);
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              out_last_nxt = 1'b1;
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = STAT_EMPTY;
              end else if (mode == MODE_POP_FRONT || count_r == CW'(1)) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = cell_data[0];
                out_status_nxt = STAT_OK;
                cell_op        = CELL_SHL;
                count_nxt      = count_r - CW'(1);
              end else begin
                // Bring the back entry round to cell zero first.
                state_nxt = ST_ROTB;
                rem_nxt   = count_r - CW'(1);
              end
            end
            MODE_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = '0;
                out_status_nxt = STAT_EMPTY;
                out_last_nxt   = 1'b1;
              end else begin
                state_nxt = ST_DUMP;
                rem_nxt   = count_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROTB: begin
        cell_op = CELL_ROT;
        rem_nxt = rem_r - CW'(1);
        if (rem_r == CW'(1)) begin
          state_nxt = ST_POPB;
        end
      end
      ST_POPB: begin
        if (out_free) begin
          cell_op        = CELL_SHL;
          count_nxt      = count_r - CW'(1);
          out_valid_nxt  = 1'b1;
          out_data_nxt   = cell_data[0];
          out_status_nxt = STAT_OK;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_DUMP: begin
        // A full rotation over all held entries leaves the order as it was.
        if (out_free) begin
          cell_op        = CELL_ROT;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = cell_data[0];
          out_status_nxt = STAT_OK;
          out_last_nxt   = (rem_r == CW'(1));
          rem_nxt        = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("entry count disagrees with occupied cells");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("input ready outside idle state");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP || state_r == ST_ROTB) |-> (rem_r != '0 && count_r != '0))
    else $error("rotation pass running on empty queue");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the double-ended queue: directed table, then random traffic.
`timescale 1ns / 100ps

module tb
  import deq_pkg::*;
();

  localparam int QDEPTH       = 32;
  localparam int RESET_CYCLES = 11;
  localparam int PHASE_ITEMS  = 57;
  localparam int HOLD_CYCLES  = 500;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 16;
  localparam int MAX_PRINTS   = 20;
  localparam int NUM_ROWS     = 23;

  // Mode codes that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    logic [5:0]        reps;
    logic              pinned;
    logic [DATA_W-1:0] pdata;
    status_t           pstat;
  } stim_row_t;

  // Pinned rows carry a result that can be read off directly; the rest use the predictor.
  // Repeated rows add the repetition index to the value.
  localparam stim_row_t DIR_TABLE [NUM_ROWS] = '{
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_POP_BACK,   32'hFFFF_FFFF, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_DUMP,       32'h1234_5678, 6'd1,  1'b1, 32'h0000_0000, STAT_EMPTY},
    '{MODE_SPARE_5,    32'hFFFF_FFFF, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_SPARE_6,    32'h8000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_SPARE_7,    32'h7FFF_FFFF, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'h8000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_DUMP,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd1,  1'b1, 32'h7FFF_FFFF, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd1,  1'b1, 32'h8000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'hFFFF_FFFF, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'h0000_0000, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd1,  1'b1, 32'hFFFF_FFFF, STAT_OK},
    '{MODE_POP_FRONT,  32'hFFFF_FFFF, 6'd1,  1'b1, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_FRONT, 32'hA5A5_0000, 6'd32, 1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'h5555_5555, 6'd1,  1'b1, 32'h0000_0000, STAT_FULL},
    '{MODE_PUSH_FRONT, 32'hAAAA_AAAA, 6'd1,  1'b1, 32'h0000_0000, STAT_FULL},
    '{MODE_DUMP,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_BACK,   32'h0000_0000, 6'd16, 1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_PUSH_BACK,  32'h0F0F_0000, 6'd8,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_DUMP,       32'h0000_0000, 6'd1,  1'b0, 32'h0000_0000, STAT_OK},
    '{MODE_POP_FRONT,  32'h0000_0000, 6'd24, 1'b0, 32'h0000_0000, STAT_OK}
  };

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [DATA_W-1:0]   in_tdata   = '0;
  logic [MODE_W-1:0]   in_tuser   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [DATA_W-1:0]   out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                out_tlast;

  // A pinned result travels beside the item so it is picked up at the same transfer.
  logic    pin_en  = 1'b0;
  result_t pin_res = '0;

  int send_pct  = 0;
  int recv_pct  = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int error_count = 0;
  int idle_cycles = 0;

  // Predictor state: ring of values, head position and fill level.
  logic [DATA_W-1:0] ring_vals [QDEPTH];
  int ring_head  = 0;
  int ring_count = 0;
  result_t pending_results [$];

  double_ended_queue #(.DEPTH(QDEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  task automatic flag_error(string msg);
    if (error_count < MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Applies one operation to the ring and queues the results it causes.
  function automatic void predict_op(logic [MODE_W-1:0] op, logic [DATA_W-1:0] value);
    int i;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (ring_count >= QDEPTH) begin
          pending_results.push_back(result_t'{'0, STAT_FULL, 1'b1});
        end else begin
          if (op == MODE_PUSH_FRONT) begin
            ring_head = (ring_head + QDEPTH - 1) % QDEPTH;
            ring_vals[ring_head] = value;
          end else begin
            ring_vals[(ring_head + ring_count) % QDEPTH] = value;
          end
          ring_count++;
          pending_results.push_back(result_t'{'0, STAT_OK, 1'b1});
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (ring_count == 0) begin
          pending_results.push_back(result_t'{'0, STAT_EMPTY, 1'b1});
        end else if (op == MODE_POP_FRONT) begin
          pending_results.push_back(result_t'{ring_vals[ring_head], STAT_OK, 1'b1});
          ring_head = (ring_head + 1) % QDEPTH;
          ring_count--;
        end else begin
          pending_results.push_back(
            result_t'{ring_vals[(ring_head + ring_count - 1) % QDEPTH], STAT_OK, 1'b1});
          ring_count--;
        end
      end
      MODE_DUMP: begin
        if (ring_count == 0) begin
          pending_results.push_back(result_t'{'0, STAT_EMPTY, 1'b1});
        end else begin
          for (i = 0; i < ring_count; i++) begin
            pending_results.push_back(result_t'{ring_vals[(ring_head + i) % QDEPTH], STAT_OK,
                                                i == ring_count - 1});
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // Offers one item after a random gap and returns at the edge where it is taken.
  task automatic offer(logic [MODE_W-1:0] op, logic [DATA_W-1:0] value, logic pinned,
                       result_t pinned_res);
    while ($urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    pin_en    <= pinned;
    pin_res   <= pinned_res;
    do @(posedge clk); while (!in_tready);
  endtask

  // Scoreboard: predict on every input transfer, check every output transfer.
  always @(posedge clk) begin : scoreboard
    result_t want;
    int base;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        base = pending_results.size();
        predict_op(in_tuser, in_tdata);
        if (pin_en && pending_results.size() > base) begin
          pending_results[base] = pin_res;
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result data=%h status=%0d last=%b",
                               out_tdata, out_tuser, out_tlast));
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.data) begin
            flag_error($sformatf("data %h, expected %h", out_tdata, want.data));
          end
          if (out_tuser !== want.status) begin
            flag_error($sformatf("status %0d, expected %0d", out_tuser, want.status));
          end
          if (out_tlast !== want.last) begin
            flag_error($sformatf("last %b, expected %b", out_tlast, want.last));
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off so the output stays full and the input stalls.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_pct);
    end
  end

  initial begin : stimulus
    int row;
    int rep;
    int phase;
    int sent;
    int push_pct;
    int r;
    logic [MODE_W-1:0] op;
    stim_row_t cur;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    send_pct = 24;
    recv_pct <= 83;

    for (row = 0; row < NUM_ROWS; row++) begin
      cur = DIR_TABLE[row];
      for (rep = 0; rep < cur.reps; rep++) begin
        offer(cur.mode, cur.value + rep, cur.pinned, result_t'{cur.pdata, cur.pstat, 1'b1});
      end
    end

    // Stretches biased toward filling or draining reach both the full and empty cases.
    push_pct = 50;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_pct = 24;
          recv_pct <= 83;
        end
        1: begin
          send_pct = 83;
          recv_pct <= 24;
        end
        default: begin
          send_pct = 0;
          recv_pct <= 0;
          hold_req <= 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 80;
            1:       push_pct = 20;
            default: push_pct = 50;
          endcase
        end
        r = $urandom_range(99);
        if (r < 3) begin
          offer(MODE_SPARE_5 + 3'($urandom_range(2)), $urandom, 1'b0, '0);
        end else begin
          if (r < 11) begin
            op = MODE_DUMP;
          end else if ($urandom_range(99) < push_pct) begin
            op = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
          end else begin
            op = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
          end
          offer(op, pick_value(), 1'b0, '0);
          sent++;
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* double_ended_queue.f */
design/deq_pkg.sv
design/deq_cell.sv
design/double_ended_queue.sv
verif/tb.sv
